// File: rtl/dmp_pkg.sv
// types and constants shared by the dual motor speed and distance controller
`timescale 1ns / 1ps
`default_nettype none

package dmp_pkg;

    localparam int ACC_W       = 56;
    localparam int FRAC_BITS   = 12;
    localparam int HALF_SCALE  = 20480;
    localparam int FRAC_SCALE  = 40960;
    localparam int RECIP_TEN   = 838861;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 20;

    typedef enum logic [2:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_LEFT_TARGET   = 3'd3,
        REG_RIGHT_TARGET  = 3'd4,
        REG_LEFT_LIMIT    = 3'd5,
        REG_RIGHT_LIMIT   = 3'd6,
        REG_DRIVE_CONTROL = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] left_count;
        logic [15:0] right_count;
    } in_t;

    typedef struct packed {
        logic [6:0] left_duty;
        logic [6:0] right_duty;
        logic       left_direction;
        logic       right_direction;
        logic       left_done;
        logic       right_done;
    } out_t;

    typedef struct packed {
        logic [15:0] p;
        logic [15:0] i;
        logic [15:0] d;
    } gains_t;

    typedef struct packed {
        logic [15:0] target;
        logic [30:0] limit;
    } side_cfg_t;

    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [6:0] duty;
        logic       done;
    } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/dual_motor_pid_speed_distance.sv
// top level of the dual motor pid speed controller with distance stop
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer carries one encoder count per side; both sides run the same
// pid rule in two identical five-stage lanes and their duties are merged into one
// result transfer. No new sample is taken while the last one is in the first lane
// stage: the held duty written by the last lane stage feeds the clamp stage of the
// next sample. Results wait in a QUEUE_DEPTH deep queue, so samples keep flowing
// while the output side stalls, until the queue and the lanes together hold
// QUEUE_DEPTH samples. Writing a side's target or limit restarts that side;
// configure only while no sample is in flight.
module dual_motor_pid_speed_distance #(
    parameter int DUTY_MAX    = 100,
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dmp_pkg::in_t      in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dmp_pkg::out_t          out_data,
    input  wire logic              cfg_write,
    input  wire dmp_pkg::reg_idx_t cfg_index,
    input  wire logic [30:0]       cfg_data
);

    localparam int PENW = $clog2(QUEUE_DEPTH + 1);

    dmp_pkg::gains_t    gains_reg;
    dmp_pkg::side_cfg_t left_cfg_reg;
    dmp_pkg::side_cfg_t right_cfg_reg;
    logic [2:0]         drive_control_reg;
    logic [PENW-1:0]    pending_reg, pending_next;

    logic               left_restart, right_restart;
    logic               in_fire, out_fire;
    dmp_pkg::lane_res_t left_res, right_res;
    dmp_pkg::out_t      merged;

    always_comb
    begin
        left_restart  = 1'b0;
        right_restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index) inside
                dmp_pkg::REG_LEFT_TARGET, dmp_pkg::REG_LEFT_LIMIT:   left_restart  = 1'b1;
                dmp_pkg::REG_RIGHT_TARGET, dmp_pkg::REG_RIGHT_LIMIT: right_restart = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.p          <= 16'd2458;
            gains_reg.i          <= 16'd123;
            gains_reg.d          <= 16'd0;
            left_cfg_reg         <= '0;
            right_cfg_reg        <= '0;
            drive_control_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dmp_pkg::REG_GAIN_P:        gains_reg.p          <= cfg_data[15:0];
                dmp_pkg::REG_GAIN_I:        gains_reg.i          <= cfg_data[15:0];
                dmp_pkg::REG_GAIN_D:        gains_reg.d          <= cfg_data[15:0];
                dmp_pkg::REG_LEFT_TARGET:   left_cfg_reg.target  <= cfg_data[15:0];
                dmp_pkg::REG_RIGHT_TARGET:  right_cfg_reg.target <= cfg_data[15:0];
                dmp_pkg::REG_LEFT_LIMIT:    left_cfg_reg.limit   <= cfg_data;
                dmp_pkg::REG_RIGHT_LIMIT:   right_cfg_reg.limit  <= cfg_data;
                dmp_pkg::REG_DRIVE_CONTROL: drive_control_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // samples in the lanes plus results in the queue
    assign in_ready = !left_res.busy && (pending_reg < PENW'(QUEUE_DEPTH));
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign pending_next = pending_reg + PENW'(in_fire) - PENW'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    dmp_lane #(
        .DUTY_MAX   (DUTY_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains_reg),
        .mode    (drive_control_reg[0]),
        .side    (left_cfg_reg),
        .restart (left_restart),
        .start   (in_fire),
        .count   (in_data.left_count),
        .res     (left_res)
    );

    dmp_lane #(
        .DUTY_MAX   (DUTY_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains_reg),
        .mode    (drive_control_reg[0]),
        .side    (right_cfg_reg),
        .restart (right_restart),
        .start   (in_fire),
        .count   (in_data.right_count),
        .res     (right_res)
    );

    // merge both lanes into one result
    always_comb
    begin
        merged.left_duty       = left_res.duty;
        merged.right_duty      = right_res.duty;
        merged.left_direction  = drive_control_reg[1];
        merged.right_direction = drive_control_reg[2];
        merged.left_done       = left_res.done;
        merged.right_done      = right_res.done;
    end

    dmp_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (left_res.valid),
        .push_data (merged),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (left_res.valid == right_res.valid) && (left_res.busy == right_res.busy))
        else $error("lanes out of step");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PENW'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_out_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result shown with nothing pending");

    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        left_res.valid |=> !left_res.valid)
        else $error("results closer than the duty feedback allows");

endmodule

`default_nettype wire

// File: rtl/dmp_lane.sv
// one motor lane: travel check, pid step and duty update, five pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module dmp_lane #(
    parameter int DUTY_MAX   = 100,
    parameter int COUNT_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dmp_pkg::gains_t    gains,
    input  wire logic               mode,
    input  wire dmp_pkg::side_cfg_t side,
    input  wire logic               restart,
    input  wire logic               start,
    input  wire logic [15:0]        count,
    output dmp_pkg::lane_res_t      res
);

    localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int DW = $clog2(DUTY_MAX + 1);
    localparam int DWX = (DW > 7) ? DW : 7;
    localparam int AW = dmp_pkg::ACC_W;
    localparam longint unsigned XMAX_L = longint'(DUTY_MAX) * dmp_pkg::FRAC_SCALE;
    localparam longint unsigned XTOP_L = XMAX_L + dmp_pkg::HALF_SCALE;
    localparam int XW = $clog2(XTOP_L + 1);
    localparam int YW = XW - dmp_pkg::FRAC_BITS;
    localparam int PW = (YW + dmp_pkg::RECIP_W > DW + dmp_pkg::RECIP_SHIFT)
                        ? YW + dmp_pkg::RECIP_W : DW + dmp_pkg::RECIP_SHIFT;
    localparam logic [XW-1:0] XMAX = XW'(XMAX_L);
    localparam logic [XW-1:0] XHALF = XW'(dmp_pkg::HALF_SCALE);

    // side state
    logic [31:0]        travel_reg;
    logic signed [31:0] integral_reg;
    logic signed [16:0] last_error_reg;
    logic               finished_reg;
    logic [DW-1:0]      duty_held_reg;

    // pipeline
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [15:0]        s1_count_reg;
    logic signed [16:0] s2_e_reg;
    logic signed [31:0] s2_integ_reg;
    logic signed [17:0] s2_de_reg;
    logic               s2_over_reg, s2_done_reg;
    logic signed [33:0] s3_pe_reg;
    logic signed [48:0] s3_ie_reg;
    logic signed [34:0] s3_dd_reg;
    logic               s3_over_reg, s3_done_reg;
    logic signed [AW-1:0] s4_acc_reg;
    logic               s4_over_reg, s4_done_reg;
    logic [YW-1:0]      s5_y_reg;
    logic               s5_over_reg, s5_done_reg;

    // stage 1 signals
    logic [15:0]        cnt;
    logic [32:0]        tsum;
    logic [31:0]        travel_next;
    logic               over;
    logic signed [16:0] e;
    logic signed [20:0] e10;
    logic signed [33:0] isum;
    logic signed [31:0] integ;
    logic signed [17:0] de;

    // later stage signals
    logic signed [33:0]   pe;
    logic signed [48:0]   ie;
    logic signed [34:0]   dd;
    logic signed [AW-1:0] psum;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] x;
    logic [XW-1:0]        xc;
    logic [XW-1:0]        xr;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        q;
    logic [DWX-1:0]       qx;

    assign cnt = 16'(s1_count_reg[CW-1:0]);
    assign tsum = {1'b0, travel_reg} + 33'(cnt);

    always_comb
    begin
        if (!mode)
            travel_next = travel_reg;
        else if (tsum[32])
            travel_next = '1;
        else
            travel_next = tsum[31:0];
    end

    assign over = travel_next > {1'b0, side.limit};
    assign e = $signed({1'b0, side.target}) - $signed({1'b0, cnt});
    assign e10 = (21'(e) <<< 3) + (21'(e) <<< 1);
    assign isum = 34'(integral_reg) + 34'(e10);

    always_comb
    begin
        if (isum > 34'sh0_7FFF_FFFF)
            integ = 32'sh7FFF_FFFF;
        else if (isum < 34'sh3_8000_0000)
            integ = 32'sh8000_0000;
        else
            integ = isum[31:0];
    end

    assign de = 18'(e) - 18'(last_error_reg);

    assign pe = $signed({1'b0, gains.p}) * s2_e_reg;
    assign ie = $signed({1'b0, gains.i}) * s2_integ_reg;
    assign dd = $signed({1'b0, gains.d}) * s2_de_reg;

    assign psum = AW'(s3_pe_reg) + AW'(s3_ie_reg);
    assign acc = (psum <<< 3) + (psum <<< 1) + AW'(s3_dd_reg);

    assign x = s4_acc_reg + $signed((AW'(duty_held_reg) << 15) + (AW'(duty_held_reg) << 13))
               + $signed(AW'(dmp_pkg::HALF_SCALE));

    always_comb
    begin
        if (x[AW-1])
            xc = '0;
        else if (x > $signed(AW'(XMAX)))
            xc = XMAX;
        else
            xc = XW'(x);
    end

    assign xr = xc + XHALF;

    // divide by ten through a reciprocal, exact for the value range here
    assign prod = PW'(s5_y_reg) * PW'(dmp_pkg::RECIP_TEN);
    assign q = prod[DW+dmp_pkg::RECIP_SHIFT-1:dmp_pkg::RECIP_SHIFT];
    assign qx = DWX'(q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg     <= '0;
            integral_reg   <= '0;
            last_error_reg <= '0;
            finished_reg   <= 1'b0;
        end
        else if (restart)
        begin
            travel_reg     <= '0;
            integral_reg   <= '0;
            last_error_reg <= '0;
            finished_reg   <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            travel_reg <= travel_next;
            if (over)
                finished_reg <= 1'b1;
            else
            begin
                integral_reg   <= integ;
                last_error_reg <= e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_held_reg <= '0;
        else if (s5_valid_reg && !s5_over_reg)
            duty_held_reg <= q;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            s1_count_reg <= count;
        s2_e_reg     <= e;
        s2_integ_reg <= integ;
        s2_de_reg    <= de;
        s2_over_reg  <= over;
        s2_done_reg  <= finished_reg | over;
        s3_pe_reg    <= pe;
        s3_ie_reg    <= ie;
        s3_dd_reg    <= dd;
        s3_over_reg  <= s2_over_reg;
        s3_done_reg  <= s2_done_reg;
        s4_acc_reg   <= acc;
        s4_over_reg  <= s3_over_reg;
        s4_done_reg  <= s3_done_reg;
        s5_y_reg     <= xr[XW-1:dmp_pkg::FRAC_BITS];
        s5_over_reg  <= s4_over_reg;
        s5_done_reg  <= s4_done_reg;
    end

    assign res.busy  = s1_valid_reg;
    assign res.valid = s5_valid_reg;
    assign res.duty  = s5_over_reg ? 7'd0 : qx[6:0];
    assign res.done  = s5_done_reg;

endmodule

`default_nettype wire

// File: rtl/dmp_result_queue.sv
// small result queue between the lane merge and the output channel
`timescale 1ns / 1ps
`default_nettype none

module dmp_result_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dmp_pkg::out_t push_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dmp_pkg::out_t      out_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);

    dmp_pkg::out_t   mem_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: tb/dual_motor_pid_speed_distance_tb.sv
// self-checking testbench for the dual motor pid speed controller with distance stop
`timescale 1ns / 1ps

module dual_motor_pid_speed_distance_tb;

    localparam int     DUTY_TOP     = 100;
    localparam int     WATCHDOG_MAX = 1000;
    localparam int     LONG_HOLD    = 80;
    localparam longint INTEG_MAX    = 64'sd2147483647;
    localparam longint INTEG_MIN    = -64'sd2147483648;

    typedef struct {
        logic [15:0] target;
        logic [30:0] limit;
        int          duty;
        longint      integ;
        longint      last_err;
        logic [31:0] travel;
        logic        finished;
    } lane_state_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    dmp_pkg::in_t      in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    dmp_pkg::out_t     out_data;
    logic              cfg_write = 1'b0;
    dmp_pkg::reg_idx_t cfg_index = dmp_pkg::REG_GAIN_P;
    logic [30:0]       cfg_data = '0;

    logic [15:0] gain_p = 16'd2458;
    logic [15:0] gain_i = 16'd123;
    logic [15:0] gain_d = 16'd0;
    logic [2:0]  drive_ctl = 3'd0;
    lane_state_t lane [2];

    dmp_pkg::in_t  count_q [$];
    dmp_pkg::out_t motor_cmd_q [$];
    int   mismatches = 0;
    bit   no_idle = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   long_holds = 0;
    int   since_hold = 200;
    int   idle_cycles = 0;

    dual_motor_pid_speed_distance DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void lane_restart(input int s);
        lane[s].integ    = 0;
        lane[s].last_err = 0;
        lane[s].travel   = '0;
        lane[s].finished = 1'b0;
    endfunction

    function automatic logic [6:0] lane_step(input int s, input logic [15:0] count);
        longint      e;
        longint      integ;
        longint      acc;
        longint      x;
        logic [32:0] sum;
        if (drive_ctl[0])
        begin
            sum = {17'd0, count} + {1'b0, lane[s].travel};
            lane[s].travel = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (lane[s].travel > {1'b0, lane[s].limit})
        begin
            lane[s].finished = 1'b1;
            return 7'd0;
        end
        e = longint'(lane[s].target) - longint'(count);
        integ = lane[s].integ + 10 * e;
        if (integ > INTEG_MAX)
            integ = INTEG_MAX;
        if (integ < INTEG_MIN)
            integ = INTEG_MIN;
        lane[s].integ = integ;
        acc = 10 * (longint'(gain_p) * e + longint'(gain_i) * integ)
            + longint'(gain_d) * (e - lane[s].last_err);
        lane[s].last_err = e;
        x = longint'(lane[s].duty) * dmp_pkg::FRAC_SCALE + acc + dmp_pkg::HALF_SCALE;
        if (x < 0)
            x = 0;
        if (x > longint'(DUTY_TOP) * dmp_pkg::FRAC_SCALE)
            x = longint'(DUTY_TOP) * dmp_pkg::FRAC_SCALE;
        lane[s].duty = int'((x + dmp_pkg::HALF_SCALE) / dmp_pkg::FRAC_SCALE);
        return 7'(lane[s].duty);
    endfunction

    function automatic dmp_pkg::out_t drive_predict(input dmp_pkg::in_t d);
        dmp_pkg::out_t r;
        r.left_duty       = lane_step(0, d.left_count);
        r.right_duty      = lane_step(1, d.right_count);
        r.left_direction  = drive_ctl[1];
        r.right_direction = drive_ctl[2];
        r.left_done       = lane[0].finished;
        r.right_done      = lane[1].finished;
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] t);
        int c;
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        c = int'(t) + int'($urandom_range(0, 40)) - 20;
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return 16'(c);
    endfunction

    function automatic void queue_sample(input logic [15:0] l, input logic [15:0] r);
        dmp_pkg::in_t it;
        it.left_count  = l;
        it.right_count = r;
        count_q.push_back(it);
    endfunction

    task automatic cfg_put(input dmp_pkg::reg_idx_t idx, input logic [30:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            dmp_pkg::REG_GAIN_P:        gain_p = val[15:0];
            dmp_pkg::REG_GAIN_I:        gain_i = val[15:0];
            dmp_pkg::REG_GAIN_D:        gain_d = val[15:0];
            dmp_pkg::REG_LEFT_TARGET:
            begin
                lane[0].target = val[15:0];
                lane_restart(0);
            end
            dmp_pkg::REG_RIGHT_TARGET:
            begin
                lane[1].target = val[15:0];
                lane_restart(1);
            end
            dmp_pkg::REG_LEFT_LIMIT:
            begin
                lane[0].limit = val;
                lane_restart(0);
            end
            dmp_pkg::REG_RIGHT_LIMIT:
            begin
                lane[1].limit = val;
                lane_restart(1);
            end
            dmp_pkg::REG_DRIVE_CONTROL: drive_ctl = val[2:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (count_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                motor_cmd_q.push_back(drive_predict(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (count_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= count_q.pop_front();
                    gap_left = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        dmp_pkg::out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                since_hold++;
                if (motor_cmd_q.size() == 0)
                begin
                    $error("result transfer with no sample pending");
                    mismatches++;
                end
                else
                begin
                    want = motor_cmd_q.pop_front();
                    cmp_field("left_duty", want.left_duty, out_data.left_duty);
                    cmp_field("right_duty", want.right_duty, out_data.right_duty);
                    cmp_field("left_direction", want.left_direction,
                              out_data.left_direction);
                    cmp_field("right_direction", want.right_direction,
                              out_data.right_direction);
                    cmp_field("left_done", want.left_done, out_data.left_done);
                    cmp_field("right_done", want.right_done, out_data.right_done);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_holds < 3 && since_hold >= 200 && count_q.size() >= 40)
            begin
                hold_left = LONG_HOLD;
                long_holds++;
                since_hold = 0;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("dual_motor_pid_speed_distance_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          n;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [15:0] gd;
        logic [15:0] tl;
        logic [15:0] tr;
        logic        mode;
        for (n = 0; n < 2; n++)
        begin
            lane[n].target = '0;
            lane[n].limit  = '0;
            lane[n].duty   = 0;
            lane_restart(n);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, count extremes
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h0000);
        settle();

        // gain extremes, duty driven to both clamps
        cfg_put(dmp_pkg::REG_GAIN_P, 31'd65535);
        cfg_put(dmp_pkg::REG_GAIN_I, 31'd0);
        cfg_put(dmp_pkg::REG_GAIN_D, 31'd65535);
        cfg_put(dmp_pkg::REG_LEFT_TARGET, 31'd65535);
        cfg_put(dmp_pkg::REG_RIGHT_TARGET, 31'd0);
        cfg_put(dmp_pkg::REG_DRIVE_CONTROL, 31'd6);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_sample(16'h8000, 16'h0001);
        queue_sample(16'h7FFF, 16'hFFFE);
        settle();

        // distance stop on both sides
        cfg_put(dmp_pkg::REG_GAIN_P, 31'd2458);
        cfg_put(dmp_pkg::REG_GAIN_I, 31'd123);
        cfg_put(dmp_pkg::REG_GAIN_D, 31'd4096);
        cfg_put(dmp_pkg::REG_LEFT_TARGET, 31'd100);
        cfg_put(dmp_pkg::REG_RIGHT_TARGET, 31'd50);
        cfg_put(dmp_pkg::REG_LEFT_LIMIT, 31'd10);
        cfg_put(dmp_pkg::REG_RIGHT_LIMIT, 31'd0);
        cfg_put(dmp_pkg::REG_DRIVE_CONTROL, 31'd1);
        queue_sample(16'd4, 16'd0);
        queue_sample(16'd4, 16'd0);
        queue_sample(16'd4, 16'd1);
        queue_sample(16'd0, 16'd0);
        settle();

        // restart left, held duty resumes as the base
        cfg_put(dmp_pkg::REG_LEFT_TARGET, 31'd100);
        queue_sample(16'd1, 16'd0);
        queue_sample(16'd1, 16'd0);
        settle();

        // mode off: right travel stays over its limit
        cfg_put(dmp_pkg::REG_DRIVE_CONTROL, 31'd0);
        queue_sample(16'd90, 16'd40);
        queue_sample(16'd110, 16'd60);
        settle();

        cfg_put(dmp_pkg::REG_RIGHT_LIMIT, 31'h7FFF_FFFF);
        queue_sample(16'd100, 16'd50);
        queue_sample(16'd100, 16'd50);

        for (ph = 0; ph < 5; ph++)
        begin
            settle();
            no_idle = (ph == 2);
            if (ph == 0)
            begin
                gp = '0;
                gi = '0;
                gd = '0;
            end
            else if (ph == 4)
            begin
                gp = '1;
                gi = '1;
                gd = '1;
            end
            else
            begin
                gp = 16'($urandom_range(0, 12000));
                gi = 16'($urandom_range(0, 800));
                gd = 16'($urandom_range(0, 8192));
            end
            cfg_put(dmp_pkg::REG_GAIN_P, 31'(gp));
            cfg_put(dmp_pkg::REG_GAIN_I, 31'(gi));
            cfg_put(dmp_pkg::REG_GAIN_D, 31'(gd));
            tl = (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 400));
            tr = (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 400));
            if (ph == 4 || $urandom_range(0, 3) != 0)
                cfg_put(dmp_pkg::REG_LEFT_TARGET, 31'(tl));
            if (ph == 4 || $urandom_range(0, 3) != 0)
                cfg_put(dmp_pkg::REG_RIGHT_TARGET, 31'(tr));
            mode = ph[0] || ph == 4;
            cfg_put(dmp_pkg::REG_LEFT_LIMIT, (ph == 4) ? 31'h7FFF_FFFF
                    : 31'($urandom_range(0, 60 * int'(lane[0].target) + 200)));
            cfg_put(dmp_pkg::REG_RIGHT_LIMIT, (ph == 4) ? 31'h7FFF_FFFF
                    : 31'($urandom_range(0, 60 * int'(lane[1].target) + 200)));
            cfg_put(dmp_pkg::REG_DRIVE_CONTROL, 31'({2'($urandom_range(0, 3)), mode}));
            for (n = 0; n < 110; n++)
                queue_sample(jitter(lane[0].target), jitter(lane[1].target));
        end

        // large errors of both signs at the full travel rate
        settle();
        no_idle = 1'b1;
        cfg_put(dmp_pkg::REG_GAIN_P, 31'd2458);
        cfg_put(dmp_pkg::REG_GAIN_I, 31'd123);
        cfg_put(dmp_pkg::REG_GAIN_D, 31'd0);
        cfg_put(dmp_pkg::REG_LEFT_TARGET, 31'd0);
        cfg_put(dmp_pkg::REG_RIGHT_TARGET, 31'd65535);
        cfg_put(dmp_pkg::REG_LEFT_LIMIT, 31'h7FFF_FFFF);
        cfg_put(dmp_pkg::REG_RIGHT_LIMIT, 31'h7FFF_FFFF);
        cfg_put(dmp_pkg::REG_DRIVE_CONTROL, 31'd1);
        for (n = 0; n < 8; n++)
            queue_sample(16'hFFFF, 16'h0000);
        for (n = 0; n < 8; n++)
            queue_sample(16'hFFFF, 16'hFFFF);
        settle();

        if (mismatches == 0 && motor_cmd_q.size() == 0)
            $display("dual_motor_pid_speed_distance_tb OK");
        else
            $display("dual_motor_pid_speed_distance_tb NOT OK");
        $finish;
    end

endmodule
